/* hdl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes and the record that travels down the divider chain of the
// fixed-point alu.
// ----------------------------------------------------------------------------
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_GT   = 4'd4,
		OP_LT   = 4'd5,
		OP_GE   = 4'd6,
		OP_LE   = 4'd7,
		OP_EQ   = 4'd8,
		OP_NE   = 4'd9,
		OP_MIN  = 4'd10,
		OP_MAX  = 4'd11,
		OP_INC  = 4'd12,
		OP_DEC  = 4'd13,
		OP_FINT = 4'd14,
		OP_TINT = 4'd15
	} fpa_op_t;

	// per-item record carried from cell to cell
	typedef struct packed {
		logic [31:0] res;    // result of every operation but divide
		logic        flag;
		logic        is_div;
		logic        neg;    // quotient sign
		logic        divz;   // divisor is zero
		logic [31:0] mb;     // divisor magnitude
		logic [31:0] rem;    // partial remainder
	} fpa_side_t;

endpackage

/* hdl/fpa_if.sv */
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if
// Valid/ready channels carrying one operation item and one result item.
// ----------------------------------------------------------------------------
interface fpa_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         operation;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source (output valid, operation, operand_a, operand_b, input ready);
	modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               flag;

	modport source (output valid, result_value, flag, input ready);
	modport sink   (input valid, result_value, flag, output ready);
endinterface

/* hdl/fpa_div_cell.sv */
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring division step: shifts in one numerator bit, subtracts the
// divisor when it fits and shifts the quotient bit in. Other fields ride along.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
	parameter int NB = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fpa_pkg::fpa_side_t in_side,
	input  logic [NB-1:0]      in_num,
	output logic               out_valid,
	input  logic               out_ready,
	output fpa_pkg::fpa_side_t out_side,
	output logic [NB-1:0]      out_num
);

	logic               valid_q;
	fpa_pkg::fpa_side_t side_q;
	logic [NB-1:0]      num_q;
	logic [32:0]        trial;
	logic [32:0]        diff;
	logic               fits;
	fpa_pkg::fpa_side_t side_d;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		trial = {in_side.rem, in_num[NB-1]};
		diff  = trial - {1'b0, in_side.mb};
		fits  = trial >= {1'b0, in_side.mb};
		side_d = in_side;
		side_d.rem = fits ? diff[31:0] : trial[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			side_q <= side_d;
			num_q  <= {in_num[NB-2:0], fits};
		end
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_num   = num_q;

endmodule

/* hdl/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point alu on 32-bit raw values: add, sub, mul, div, compares,
// min/max, inc/dec and integer conversion. Division runs down a chain of
// one-bit restoring cells; all other results ride the same chain.
//
//   channel  dir  fields                                  handshake
//   req      in   operation, operand_a, operand_b         valid/ready
//   rsp      out  result_value, flag                      valid/ready
//
// one front stage (alu, 32x32 multiply), 32 + FRAC_BITS divider cells, one
// rounding/output stage. a new item is taken every cycle unless stalled;
// each stage moves when the one after it is empty or moving, so a stalled
// result only holds what sits behind it.
// reset clears the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input logic           clk,
	input logic           arst_n,
	fpa_req_if.sink       req,
	fpa_rsp_if.source     rsp
);

	localparam int NB = 32 + FRAC_BITS;

	// front stage
	logic               v_s1;
	logic               rdy_s1;
	fpa_pkg::fpa_side_t side_s1;
	logic [NB-1:0]      num_s1;
	logic signed [63:0] prod_s1;
	logic               mul_s1;

	fpa_pkg::fpa_side_t side_d;
	logic [NB-1:0]      num_d;
	logic [31:0]        ua, ub, ma, mb;
	logic               a_lt_b, b_lt_a;
	fpa_pkg::fpa_side_t chain_side;

	always_comb begin
		ua = req.operand_a;
		ub = req.operand_b;
		a_lt_b = req.operand_a < req.operand_b;
		b_lt_a = req.operand_b < req.operand_a;
		ma = ua[31] ? 32'(-ua) : ua;
		mb = ub[31] ? 32'(-ub) : ub;
		side_d = '0;
		side_d.mb = mb;
		side_d.neg = ua[31] ^ ub[31];
		side_d.divz = (ub == 32'd0);
		case (fpa_pkg::fpa_op_t'(req.operation))
			fpa_pkg::OP_ADD:  side_d.res = ua + ub;
			fpa_pkg::OP_SUB:  side_d.res = ua - ub;
			fpa_pkg::OP_DIV:  side_d.is_div = 1'b1;
			fpa_pkg::OP_GT:   side_d.flag = b_lt_a;
			fpa_pkg::OP_LT:   side_d.flag = a_lt_b;
			fpa_pkg::OP_GE:   side_d.flag = !a_lt_b;
			fpa_pkg::OP_LE:   side_d.flag = !b_lt_a;
			fpa_pkg::OP_EQ:   side_d.flag = (ua == ub);
			fpa_pkg::OP_NE:   side_d.flag = (ua != ub);
			fpa_pkg::OP_MIN:  side_d.res = b_lt_a ? ub : ua;
			fpa_pkg::OP_MAX:  side_d.res = a_lt_b ? ub : ua;
			fpa_pkg::OP_INC:  side_d.res = ua + 32'd1;
			fpa_pkg::OP_DEC:  side_d.res = ua - 32'd1;
			fpa_pkg::OP_FINT: side_d.res = ua << FRAC_BITS;
			fpa_pkg::OP_TINT: side_d.res = 32'(req.operand_a >>> FRAC_BITS);
			default:          side_d.res = '0;
		endcase
		num_d = NB'(ma) << FRAC_BITS;
	end

	logic               cv   [NB+1];
	logic               crdy [NB+1];
	fpa_pkg::fpa_side_t cside[NB+1];
	logic [NB-1:0]      cnum [NB+1];

	assign rdy_s1    = !v_s1 || crdy[0];
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req.valid) begin
			side_s1 <= side_d;
			num_s1  <= num_d;
			prod_s1 <= req.operand_a * req.operand_b;
			mul_s1  <= (fpa_pkg::fpa_op_t'(req.operation) == fpa_pkg::OP_MUL);
		end
	end

	// product shift is a fixed bit slice
	always_comb begin
		chain_side = side_s1;
		if (mul_s1) begin
			chain_side.res = prod_s1[FRAC_BITS +: 32];
		end
	end

	assign cv[0]    = v_s1;
	assign cside[0] = chain_side;
	assign cnum[0]  = num_s1;

	for (genvar i = 0; i < NB; i++) begin : g_cell
		fpa_div_cell #(.NB(NB)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (crdy[i]),
			.in_side   (cside[i]),
			.in_num    (cnum[i]),
			.out_valid (cv[i+1]),
			.out_ready (crdy[i+1]),
			.out_side  (cside[i+1]),
			.out_num   (cnum[i+1])
		);
	end

	// rounding and output register
	logic               rsp_valid_q;
	logic [31:0]        rsp_res_q;
	logic               rsp_flag_q;
	logic               rsp_divz_q;
	fpa_pkg::fpa_side_t fs;
	logic [31:0]        q_rnd;
	logic [31:0]        res_d;
	logic               flag_d;

	assign crdy[NB] = !rsp_valid_q || rsp.ready;

	always_comb begin
		fs = cside[NB];
		// half away from zero on magnitudes: 2r >= divisor
		q_rnd = cnum[NB][31:0] + 32'({fs.rem, 1'b0} >= {1'b0, fs.mb});
		res_d = fs.res;
		flag_d = fs.flag;
		if (fs.is_div) begin
			if (fs.divz) begin
				res_d = '0;
				flag_d = 1'b1;
			end else begin
				res_d = fs.neg ? 32'(-q_rnd) : q_rnd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (crdy[NB]) begin
			rsp_valid_q <= cv[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (crdy[NB] && cv[NB]) begin
			rsp_res_q  <= res_d;
			rsp_flag_q <= flag_d;
			rsp_divz_q <= fs.is_div && fs.divz;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_res_q;
	assign rsp.flag         = rsp_flag_q;

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted item did not reach front stage");

	a_divz_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_divz_q |-> rsp_res_q == 32'd0 && rsp_flag_q)
		else $error("divide by zero result wrong");

	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cv[NB] && !crdy[NB] |=> cv[NB])
		else $error("last divider cell dropped an item");

endmodule

/* verif/fixed_point_alu_tb.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_tb
// Self-checking bench for the fixed-point alu. A directed set of corner
// items comes first, then random items. Bursty input, patterned output
// stalls and one long output hold-off are applied. Each result is compared
// against a behavioral computation of the operation.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 8;
	localparam int LAT = 34 + FRAC;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic [31:0] value;
		logic        flag;
	} alu_result_t;

	// computes the result of one item at the block's widths
	function automatic alu_result_t alu_compute(fpa_pkg::fpa_op_t op, logic [31:0] a,
			logic [31:0] b);
		alu_result_t r;
		logic signed [63:0] prod;
		logic [63:0] ma, mb, num, q, rm;
		r = '0;
		case (op)
			fpa_pkg::OP_ADD: r.value = a + b;
			fpa_pkg::OP_SUB: r.value = a - b;
			fpa_pkg::OP_MUL: begin
				prod = $signed(a) * $signed(b);
				prod = prod >>> FRAC;
				r.value = prod[31:0];
			end
			fpa_pkg::OP_DIV: begin
				if (b == 0) begin
					r.flag = 1'b1;
				end else begin
					ma = a[31] ? -{{32{a[31]}}, a} : {32'd0, a};
					mb = b[31] ? -{{32{b[31]}}, b} : {32'd0, b};
					num = ma << FRAC;
					q = num / mb;
					rm = num % mb;
					if (rm >= mb - rm) q = q + 1;
					if (a[31] != b[31]) q = -q;
					r.value = q[31:0];
				end
			end
			fpa_pkg::OP_GT: r.flag = $signed(a) > $signed(b);
			fpa_pkg::OP_LT: r.flag = $signed(a) < $signed(b);
			fpa_pkg::OP_GE: r.flag = $signed(a) >= $signed(b);
			fpa_pkg::OP_LE: r.flag = $signed(a) <= $signed(b);
			fpa_pkg::OP_EQ: r.flag = a == b;
			fpa_pkg::OP_NE: r.flag = a != b;
			fpa_pkg::OP_MIN: r.value = ($signed(b) < $signed(a)) ? b : a;
			fpa_pkg::OP_MAX: r.value = ($signed(a) < $signed(b)) ? b : a;
			fpa_pkg::OP_INC: r.value = a + 1;
			fpa_pkg::OP_DEC: r.value = a - 1;
			fpa_pkg::OP_FINT: r.value = a << FRAC;
			default: r.value = $signed(a) >>> FRAC;
		endcase
		return r;
	endfunction

	class alu_scoreboard;
		alu_result_t pending[$];
		int errors;

		function void note_item(fpa_pkg::fpa_op_t op, logic [31:0] a, logic [31:0] b);
			pending.push_back(alu_compute(op, a, b));
		endfunction

		function void check_result(logic [31:0] value, logic flag);
			alu_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h flag %b", value, flag);
				return;
			end
			e = pending.pop_front();
			if (e.value !== value || e.flag !== flag) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h/%b got %h/%b", e.value, e.flag, value, flag);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	longint cycles;
	int hold_off;
	bit stall_enable;
	alu_scoreboard board;

	fpa_req_if req ();
	fpa_rsp_if rsp ();

	fixed_point_alu #(.FRAC_BITS(FRAC)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = '0;
		req.operand_a = '0;
		req.operand_b = '0;
		rsp.ready = 1'b0;
		hold_off = 0;
		stall_enable = 1'b0;
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: long hold-off when requested, otherwise a stall pattern once enabled, else always ready
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) board.check_result(rsp.result_value, rsp.flag);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 1'b0;
		end else if (!stall_enable) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 3) == 0);
		end
	end

	// track accepted items
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			board.note_item(fpa_pkg::fpa_op_t'(req.operation), req.operand_a, req.operand_b);
	end

	// offers one item and holds it until accepted
	task automatic send_item(fpa_pkg::fpa_op_t op, logic [31:0] a, logic [31:0] b);
		req.valid <= 1'b1;
		req.operation <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic idle_cycles(int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return $urandom_range(0, 4) - 2;
			3: return $urandom_range(0, 1023) - 512;
			4: return ($urandom_range(0, 1) ? 32'hffff_ffff : 32'h1) << $urandom_range(0, 31);
			5: return ($urandom & 32'h0000_ffff) | ($urandom_range(0, 1) ? 32'hffff_0000 : 32'h0);
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0] corner [6];
		fpa_pkg::fpa_op_t op;
		int burst;
		corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operation once, then the special cases
		for (int i = 0; i < 16; i++)
			send_item(fpa_pkg::fpa_op_t'(i), corner[i % 6], corner[(i + 3) % 6]);
		send_item(fpa_pkg::OP_DIV, 32'h1234, 32'h0);
		send_item(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ff00);
		send_item(fpa_pkg::OP_DIV, 32'h180, 32'h200);
		send_item(fpa_pkg::OP_DIV, 32'hffff_fe80, 32'h200);
		send_item(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_item(fpa_pkg::OP_MIN, 32'h55, 32'h55);
		send_item(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
		send_item(fpa_pkg::OP_TINT, 32'hffff_ffff, 32'h0);
		send_item(fpa_pkg::OP_GE, 32'h7fff_ffff, 32'h7fff_ffff);
		idle_cycles(1);

		// sender pauses until everything is back
		wait_drained();
		stall_enable = 1'b1;

		for (int n = 0; n < 1400; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) begin
				// long output hold-off while the sender keeps offering
				if (n == 300) hold_off = 200;
				op = fpa_pkg::fpa_op_t'($urandom_range(0, 15));
				if ($urandom_range(0, 3) == 0) op = fpa_pkg::OP_DIV;
				send_item(op, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
				n++;
			end
			if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
		end
		idle_cycles(1);
		wait_drained();
		repeat (LAT + 10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

/* sim.f */
hdl/fpa_pkg.sv
hdl/fpa_if.sv
hdl/fpa_div_cell.sv
hdl/fixed_point_alu.sv
verif/fixed_point_alu_tb.sv
